@@ src/dpq_pkg.sv @@
// Shared types and constants for the double-ended priority queue.
// Holds item structs, opcode and status codes, cell command and FSM state types.
// No dependencies.
package dpq_pkg;

   // Number of cells in the sorted chain
   localparam int unsigned CAPACITY = 64;

   localparam int unsigned KEY_W = 32;
   localparam int unsigned ID_W  = 20;

   // Request opcodes; the remaining code leaves the store alone
   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_POP_HIGH = 2'd1,
      OP_POP_LOW  = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_DUP   = 2'd3
   } status_type;

   // Command broadcast to every cell
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_COMPARE,
      CMD_INSERT,
      CMD_POP_LOW,
      CMD_POP_HIGH
   } cell_cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [KEY_W-1:0] priority_req;
      logic [ID_W-1:0]         client_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] served_id;
      logic [1:0]      status;
   } rsp_type;

   // Contents of one cell as seen by its neighbours
   typedef struct packed {
      logic                    vld;
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } cell_data_type;

   // Broadcast control to the chain
   typedef struct packed {
      cell_cmd_type            cmd;
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } cell_ctl_type;

endpackage

@@ src/double_ended_priority_queue.sv @@
// Top level of the double-ended priority queue: sequencer, cell chain, result register.
// Depends on dpq_pkg and dpq_cell.
//
// Usage:
//   Request channel req_valid / req_stall / req_item carries an opcode (insert,
//   pop highest key, pop lowest key), a signed 32-bit key and a 20-bit client id.
//   Response channel rsp_valid / rsp_stall / rsp_item returns one item per
//   request: the served client id (0 when nothing is removed) and a status
//   (ok, empty, full insert dropped, duplicate key dropped).
//   Entries sit sorted by key in a chain of CAPACITY cells, lowest key in cell 0.
//   A request passes through accept, then a compare cycle in which every cell
//   checks its key against the request key, then an apply cycle in which a
//   successful request updates the chain (insert moves entries above the
//   insertion point up one place, pop lowest shifts all down, pop highest
//   clears the topmost valid cell) and the result register is loaded.
//   The response appears the cycle after the apply cycle, and a new request can
//   be taken in that same cycle. req_stall is high while a request is in flight.
//   If the receiver stalls with a result pending, the request in flight waits in
//   the apply cycle until the result register frees up, and the input stays stalled.
//   Reset (synchronous, active high) empties the chain at once; no clearing pass.
module double_ended_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpq_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dpq_pkg::rsp_type rsp_item
);
   import dpq_pkg::*;

   state_type     state_ff, state_in;
   req_type       req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_item_ff;

   cell_ctl_type  ctl;
   cell_data_type cell_data  [CAPACITY];
   cell_data_type left_data  [CAPACITY];
   cell_data_type right_data [CAPACITY];
   logic [CAPACITY-1:0] left_lt_vec;
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] vld_vec;
   logic [CAPACITY-1:0] last_vec;

   logic            rsp_free;
   logic            apply_go;
   logic            dup;
   logic            full;
   logic            empty;
   status_type      status;
   logic [ID_W-1:0] served_hi;
   logic [ID_W-1:0] served;

   // Cell chain with neighbour wiring
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i]   = '0;
         assign left_lt_vec[i] = 1'b1;
      end else begin : g_mid_left
         assign left_data[i]   = cell_data[i-1];
         assign left_lt_vec[i] = lt_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data[i] = '0;
      end else begin : g_mid_right
         assign right_data[i] = cell_data[i+1];
      end

      dpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_data  (left_data[i]),
         .left_lt    (left_lt_vec[i]),
         .right_data (right_data[i]),
         .data       (cell_data[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );

      assign vld_vec[i] = cell_data[i].vld;
   end

   // Topmost valid cell marker
   assign last_vec = vld_vec & ~{1'b0, vld_vec[CAPACITY-1:1]};

   // Id of the highest entry
   always_comb begin
      served_hi = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (last_vec[i]) begin
            served_hi = served_hi | cell_data[i].id;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign apply_go = (state_ff == S_APPLY) && rsp_free;
   assign dup      = |eq_vec;
   assign full     = vld_vec[CAPACITY-1];
   assign empty    = !vld_vec[0];

   // Result of the held request
   always_comb begin
      status = ST_OK;
      served = '0;
      case (req_ff.op)
         OP_INSERT: begin
            if (dup) begin
               status = ST_DUP;
            end else if (full) begin
               status = ST_FULL;
            end
         end
         OP_POP_HIGH: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               served = served_hi;
            end
         end
         OP_POP_LOW: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               served = cell_data[0].id;
            end
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and chain command
   always_comb begin
      req_stall = 1'b1;
      ctl.cmd   = CMD_HOLD;
      ctl.key   = req_ff.priority_req;
      ctl.id    = req_ff.client_id;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_CMP: begin
            ctl.cmd = CMD_COMPARE;
         end
         S_APPLY: begin
            if (rsp_free) begin
               case (req_ff.op)
                  OP_INSERT:   if (status == ST_OK) ctl.cmd = CMD_INSERT;
                  OP_POP_HIGH: if (!empty) ctl.cmd = CMD_POP_HIGH;
                  OP_POP_LOW:  if (!empty) ctl.cmd = CMD_POP_LOW;
                  default:     ctl.cmd = CMD_HOLD;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_item;
      end
      if (apply_go) begin
         rsp_item_ff.served_id <= served;
         rsp_item_ff.status    <= status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // Valid cells always form a prefix of the chain
   a_vld_prefix: assert property (@(posedge clock) disable iff (reset)
      (vld_vec[CAPACITY-1:1] & ~vld_vec[CAPACITY-2:0]) == '0)
      else $error("valid cells not contiguous from cell 0");

   // A result only appears after an apply cycle
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("result raised outside apply cycle");

   // A successful insert grows the store by exactly one entry
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_INSERT) |=>
         ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
      else $error("insert did not add exactly one entry");

   // A pop removes exactly one entry
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_POP_HIGH || ctl.cmd == CMD_POP_LOW) |=>
         ($countones(vld_vec) + 1 == $past($countones(vld_vec))))
      else $error("pop did not remove exactly one entry");
`endif

endmodule

@@ src/dpq_cell.sv @@
// One cell of the sorted chain: holds a key, an id and a valid bit.
// Compares against the broadcast key and shifts to or from its neighbours.
// Depends on dpq_pkg.
module dpq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dpq_pkg::cell_ctl_type  ctl,
   input  dpq_pkg::cell_data_type left_data,
   input  logic                  left_lt,
   input  dpq_pkg::cell_data_type right_data,
   output dpq_pkg::cell_data_type data,
   output logic                  lt,
   output logic                  eq
);
   import dpq_pkg::*;

   cell_data_type data_ff, data_in;
   logic          lt_ff, lt_in;
   logic          eq_ff, eq_in;

   // Next contents of the cell
   always_comb begin
      data_in = data_ff;
      lt_in   = lt_ff;
      eq_in   = eq_ff;
      case (ctl.cmd)
         CMD_COMPARE: begin
            lt_in = data_ff.vld && (data_ff.key < ctl.key);
            eq_in = data_ff.vld && (data_ff.key == ctl.key);
         end
         CMD_INSERT: begin
            // smaller keys stay; the insertion point takes the new entry;
            // everything above moves up one place
            if (!lt_ff) begin
               if (left_lt) begin
                  data_in.vld = 1'b1;
                  data_in.key = ctl.key;
                  data_in.id  = ctl.id;
               end else begin
                  data_in = left_data;
               end
            end
         end
         CMD_POP_LOW: begin
            data_in = right_data;
         end
         CMD_POP_HIGH: begin
            // topmost valid cell drops out
            if (data_ff.vld && !right_data.vld) begin
               data_in.vld = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Valid bit is control state; key, id and flags are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.vld <= 1'b0;
      end else begin
         data_ff.vld <= data_in.vld;
      end
      data_ff.key <= data_in.key;
      data_ff.id  <= data_in.id;
      lt_ff       <= lt_in;
      eq_ff       <= eq_in;
   end

   assign data = data_ff;
   assign lt   = lt_ff;
   assign eq   = eq_ff;

endmodule

@@ bench/double_ended_priority_queue_test.sv @@
// Self-checking bench for the double-ended priority queue: directed cases, fill to capacity,
// receiver hold-off, a drain pause and random traffic, all checked against a sorted-list model.
// Depends on dpq_pkg and double_ended_priority_queue.
module double_ended_priority_queue_test;
   import dpq_pkg::*;

   // Spare opcode: leaves the store alone, answers ok with id 0
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   // Predicted store contents, ascending key order
   logic signed [KEY_W-1:0] model_keys[$];
   logic [ID_W-1:0]         model_ids[$];
   // Replies still owed by the block, oldest first
   rsp_type                 pending_replies[$];

   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned insert_pct;
   int          hold_requests;
   int          holds_served;
   int          mismatch_count;
   int          cycle_count;
   rsp_type     want_reply;

   double_ended_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one request to the model and return the reply it owes
   function automatic rsp_type serve_request(input req_type r);
      rsp_type                 res;
      logic signed [KEY_W-1:0] key;
      int                      pos;
      res.served_id = '0;
      res.status    = ST_OK;
      key           = r.priority_req;
      case (r.op)
         OP_INSERT: begin
            pos = 0;
            while (pos < model_keys.size() && model_keys[pos] < key)
               pos++;
            if (pos < model_keys.size() && model_keys[pos] == key)
               res.status = ST_DUP;
            else if (model_keys.size() >= int'(CAPACITY))
               res.status = ST_FULL;
            else begin
               model_keys.insert(pos, key);
               model_ids.insert(pos, r.client_id);
            end
         end
         OP_POP_HIGH: begin
            if (model_keys.size() == 0)
               res.status = ST_EMPTY;
            else begin
               res.served_id = model_ids.pop_back();
               void'(model_keys.pop_back());
            end
         end
         OP_POP_LOW: begin
            if (model_keys.size() == 0)
               res.status = ST_EMPTY;
            else begin
               res.served_id = model_ids.pop_front();
               void'(model_keys.pop_front());
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type make_request(input logic [1:0] op,
                                            input logic signed [KEY_W-1:0] key,
                                            input logic [ID_W-1:0] id);
      req_type r;
      r.op           = op;
      r.priority_req = key;
      r.client_id    = id;
      return r;
   endfunction

   // Random request; keys lean towards a narrow band and stored keys so duplicates occur
   function automatic req_type random_request();
      req_type     r;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         r.op = OP_SPARE;
      else if (roll < 3 + insert_pct * 97 / 100)
         r.op = OP_INSERT;
      else if ($urandom_range(1))
         r.op = OP_POP_HIGH;
      else
         r.op = OP_POP_LOW;
      roll = $urandom_range(99);
      if (roll < 40)
         r.priority_req = $urandom_range(47) - 24;
      else if (roll < 60 && model_keys.size() > 0)
         r.priority_req = model_keys[$urandom_range(model_keys.size() - 1)];
      else if (roll < 70) begin
         case ($urandom_range(3))
            0: r.priority_req = 32'h7fff_ffff;
            1: r.priority_req = 32'h8000_0000;
            2: r.priority_req = 32'h7fff_fffe;
            default: r.priority_req = 32'h8000_0001;
         endcase
      end else
         r.priority_req = $urandom;
      r.client_id = ID_W'($urandom_range(20'hfffff));
      return r;
   endfunction

   // Offer one item after a random gap, wait for acceptance, then record its reply
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid              <= 1'b0;
         req_item.priority_req  <= $urandom;
         req_item.client_id     <= ID_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_replies.push_back(serve_request(item));
   endtask

   task automatic wait_for_replies();
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   // Empty stores, extreme keys and ids, duplicates at both ends, spare opcode
   task automatic test_directed_cases();
      idle_pct  = 0;
      stall_pct = 0;
      send_request(make_request(OP_POP_HIGH, '0, '0));
      send_request(make_request(OP_POP_LOW, '0, '0));
      send_request(make_request(OP_SPARE, 32'h1234_5678, 20'h00abc));
      send_request(make_request(OP_INSERT, 32'h7fff_ffff, 20'hfffff));
      send_request(make_request(OP_INSERT, 32'h8000_0000, 20'h00000));
      send_request(make_request(OP_INSERT, 32'h0000_0000, 20'h55555));
      send_request(make_request(OP_INSERT, 32'h7fff_ffff, 20'h12345));
      send_request(make_request(OP_INSERT, 32'h8000_0000, 20'h54321));
      send_request(make_request(OP_INSERT, 32'hffff_ffff, 20'haaaaa));
      send_request(make_request(OP_SPARE, 32'hffff_ffff, 20'hfffff));
      send_request(make_request(OP_POP_HIGH, '0, '0));
      send_request(make_request(OP_POP_LOW, '0, '0));
      send_request(make_request(OP_POP_LOW, '0, '0));
      send_request(make_request(OP_POP_HIGH, '0, '0));
      send_request(make_request(OP_POP_HIGH, '0, '0));
      send_request(make_request(OP_POP_LOW, '0, '0));
      send_request(make_request(OP_INSERT, 32'h0000_0001, 20'h00001));
      send_request(make_request(OP_INSERT, 32'hffff_fffe, 20'h80000));
      send_request(make_request(OP_POP_LOW, 32'hffff_ffff, 20'hfffff));
      send_request(make_request(OP_POP_HIGH, '0, '0));
   endtask

   // Fill past capacity in shuffled order, hit duplicate and full, then drain past empty
   task automatic test_fill_to_capacity();
      logic signed [KEY_W-1:0] base;
      int                      i;
      idle_pct  = 21;
      stall_pct = 21;
      while (model_keys.size() > 0)
         send_request(make_request(OP_POP_LOW, '0, '0));
      base = $urandom;
      for (i = 0; i < int'(CAPACITY) + 3; i++)
         send_request(make_request(OP_INSERT,
                                   base + KEY_W'(((i * 37) % (int'(CAPACITY) + 3)) * 5),
                                   ID_W'($urandom_range(20'hfffff))));
      // duplicate is reported ahead of full
      send_request(make_request(OP_INSERT, base, 20'h0f0f0));
      send_request(make_request(OP_INSERT, base + 1, 20'hf0f0f));
      for (i = 0; i < int'(CAPACITY) + 2; i++)
         send_request(make_request(i[0] ? OP_POP_LOW : OP_POP_HIGH, $urandom,
                                   ID_W'($urandom)));
   endtask

   // Random traffic; the insert bias swings every few dozen items to fill and drain
   task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                      input int count);
      int i;
      idle_pct  = idle;
      stall_pct = stall;
      for (i = 0; i < count; i++) begin
         if (i % 32 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         send_request(random_request());
      end
   endtask

   // Receiver holds off for a long stretch while items keep coming
   task automatic test_receiver_hold();
      int i;
      idle_pct   = 0;
      stall_pct  = 0;
      insert_pct = 70;
      hold_requests++;
      for (i = 0; i < 24; i++)
         send_request(random_request());
   endtask

   // Sender stops until every reply is in, then carries on
   task automatic test_pause_until_drained();
      int i;
      idle_pct   = 0;
      stall_pct  = 21;
      insert_pct = 60;
      for (i = 0; i < 20; i++)
         send_request(random_request());
      req_valid <= 1'b0;
      wait_for_replies();
      for (i = 0; i < 20; i++)
         send_request(random_request());
   endtask

   // Receiver: random stall, or a long hold-off when one is requested
   initial begin
      int hold_left;
      rsp_stall    = 1'b0;
      holds_served = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else
            rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Check every accepted reply against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected item: served_id %0h status %0d",
                   rsp_item.served_id, rsp_item.status);
            mismatch_count++;
         end else begin
            want_reply = pending_replies.pop_front();
            if (rsp_item.served_id !== want_reply.served_id) begin
               $error("served_id: expected %0h, got %0h",
                      want_reply.served_id, rsp_item.served_id);
               mismatch_count++;
            end
            if (rsp_item.status !== want_reply.status) begin
               $error("status: expected %0d, got %0d", want_reply.status, rsp_item.status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_item       = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      insert_pct     = 50;
      hold_requests  = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_fill_to_capacity();
      test_random_traffic(0, 0, 380);
      test_receiver_hold();
      test_random_traffic(65, 0, 380);
      test_pause_until_drained();
      test_random_traffic(0, 65, 380);
      test_random_traffic(21, 21, 380);
      req_valid <= 1'b0;
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
